// ----- rtl/slt_pkg.sv -----
`default_nettype none
package slt_pkg;

  // Result events.
  localparam logic [2:0] EV_BYTE     = 3'd0;
  localparam logic [2:0] EV_WORD_END = 3'd1;
  localparam logic [2:0] EV_OP       = 3'd2;
  localparam logic [2:0] EV_ERR      = 3'd3;
  localparam logic [2:0] EV_LINE_END = 3'd4;

  // Operator codes.
  localparam logic [2:0] OP_PIPE   = 3'd0;
  localparam logic [2:0] OP_DETACH = 3'd1;
  localparam logic [2:0] OP_AND    = 3'd2;
  localparam logic [2:0] OP_OR     = 3'd3;
  localparam logic [2:0] OP_SEMI   = 3'd4;

  // Error codes.
  localparam logic ERR_BAD_PAIR  = 1'b0;
  localparam logic ERR_BAD_PLACE = 1'b1;

  // Held operator kinds.
  localparam logic [1:0] HK_NONE = 2'd0;
  localparam logic [1:0] HK_BAR  = 2'd1;
  localparam logic [1:0] HK_AMP  = 2'd2;
  localparam logic [1:0] HK_SEMI = 2'd3;

  // Quote modes.
  localparam logic [1:0] QM_NORMAL = 2'd0;
  localparam logic [1:0] QM_SINGLE = 2'd1;
  localparam logic [1:0] QM_DOUBLE = 2'd2;

  // Kind of the previous token.
  localparam logic [1:0] PK_NONE = 2'd0;
  localparam logic [1:0] PK_CMD  = 2'd1;
  localparam logic [1:0] PK_ARG  = 2'd2;
  localparam logic [1:0] PK_OP   = 2'd3;

  // Byte values.
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam int SLT_MAX_RES     = 4;
  localparam int SLT_QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] char_out;
    logic       word_label;
    logic [2:0] op_code;
    logic       error_code;
  } slt_res_t;

  // All results caused by one byte; last_idx is the index of the final one.
  typedef struct packed {
    slt_res_t [SLT_MAX_RES-1:0] res;
    logic [1:0]                 last_idx;
  } slt_bundle_t;

endpackage
`default_nettype wire

// ----- rtl/slt_if.sv -----
`default_nettype none
interface slt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_line;

  modport source(output valid, output char_in, output end_of_line, input ready);
  modport sink(input valid, input char_in, input end_of_line, output ready);
endinterface

interface slt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] char_out;
  logic       word_label;
  logic [2:0] op_code;
  logic       error_code;
  logic       last_of_run;

  modport source(output valid, output event_res, output char_out, output word_label,
                 output op_code, output error_code, output last_of_run, input ready);
  modport sink(input valid, input event_res, input char_out, input word_label,
               input op_code, input error_code, input last_of_run, output ready);
endinterface
`default_nettype wire

// ----- rtl/slt_front.sv -----
`default_nettype none
module slt_front (
  input  logic               clk,
  input  logic               rst_n,
  slt_in_if.sink             in_ch,
  input  logic               q_full,
  output logic               push,
  output slt_pkg::slt_bundle_t push_data
);
  import slt_pkg::*;

  typedef struct packed {
    logic [1:0] quote;
    logic [1:0] held;
    logic       word_open;
    logic [1:0] prev;
    logic       err_seen;
  } slt_state_t;

  typedef struct packed {
    slt_state_t                 st;
    slt_res_t [SLT_MAX_RES-1:0] res;
    logic [2:0]                 n;
  } slt_work_t;

  slt_state_t state_r;
  slt_state_t state_nxt;
  slt_work_t  work;
  logic       accept;

  function automatic slt_res_t mk_res(logic [2:0] ev, logic [7:0] ch, logic lab,
                                      logic [2:0] op, logic err);
    slt_res_t r;
    r.event_res  = ev;
    r.char_out   = ch;
    r.word_label = lab;
    r.op_code    = op;
    r.error_code = err;
    return r;
  endfunction

  function automatic slt_work_t f_put(slt_work_t w, slt_res_t r);
    slt_work_t o;
    o = w;
    if (w.n < 3'(SLT_MAX_RES)) begin
      o.res[w.n[1:0]] = r;
      o.n = w.n + 3'd1;
    end
    return o;
  endfunction

  function automatic logic [1:0] op_kind(logic [7:0] c);
    logic [1:0] k;
    k = HK_NONE;
    if (c == CH_BAR) k = HK_BAR;
    else if (c == CH_AMP) k = HK_AMP;
    else if (c == CH_SEMI) k = HK_SEMI;
    return k;
  endfunction

  function automatic slt_work_t f_error(slt_work_t w, logic code);
    slt_work_t o;
    o = f_put(w, mk_res(EV_ERR, 8'd0, 1'b0, OP_PIPE, code));
    o.st.err_seen  = 1'b1;
    o.st.held      = HK_NONE;
    o.st.word_open = 1'b0;
    return o;
  endfunction

  // An operator is legal only right after a word.
  function automatic slt_work_t f_emit_op(slt_work_t w, logic [2:0] code);
    slt_work_t o;
    if (w.st.prev == PK_CMD || w.st.prev == PK_ARG) begin
      o = f_put(w, mk_res(EV_OP, 8'd0, 1'b0, code, ERR_BAD_PAIR));
      o.st.prev = PK_OP;
    end else begin
      o = f_error(w, ERR_BAD_PLACE);
    end
    return o;
  endfunction

  function automatic slt_work_t f_resolve(slt_work_t w, logic [1:0] h);
    slt_work_t o;
    if (h == HK_BAR) o = f_emit_op(w, OP_PIPE);
    else if (h == HK_AMP) o = f_emit_op(w, OP_DETACH);
    else o = f_emit_op(w, OP_SEMI);
    return o;
  endfunction

  function automatic slt_work_t f_append(slt_work_t w, logic [7:0] c);
    slt_work_t o;
    o = w;
    if (!o.st.word_open) begin
      o.st.word_open = 1'b1;
      o.st.prev = (o.st.prev == PK_CMD || o.st.prev == PK_ARG) ? PK_ARG : PK_CMD;
    end
    o = f_put(o, mk_res(EV_BYTE, c, o.st.prev == PK_ARG, OP_PIPE, ERR_BAD_PAIR));
    return o;
  endfunction

  function automatic slt_work_t f_close(slt_work_t w);
    slt_work_t o;
    o = w;
    if (w.st.word_open) begin
      o = f_put(w, mk_res(EV_WORD_END, 8'd0, w.st.prev == PK_ARG, OP_PIPE, ERR_BAD_PAIR));
      o.st.word_open = 1'b0;
    end
    return o;
  endfunction

  function automatic slt_work_t f_process(slt_work_t w, logic [7:0] c);
    slt_work_t  o;
    logic [1:0] k;
    o = w;
    k = op_kind(c);
    if (w.st.quote == QM_SINGLE) begin
      if (c == CH_SQUOTE) o.st.quote = QM_NORMAL;
      else o = f_append(w, c);
    end else if (w.st.quote == QM_DOUBLE) begin
      if (c == CH_DQUOTE) o.st.quote = QM_NORMAL;
      else o = f_append(w, c);
    end else if (c == CH_SQUOTE) begin
      o.st.quote = QM_SINGLE;
    end else if (c == CH_DQUOTE) begin
      o.st.quote = QM_DOUBLE;
    end else if (c == CH_SPACE || c == CH_TAB) begin
      o = f_close(w);
    end else if (k != HK_NONE) begin
      o = f_close(w);
      o.st.held = k;
    end else begin
      o = f_append(w, c);
    end
    return o;
  endfunction

  always_comb begin
    logic [1:0] h;
    logic [1:0] k;
    work    = '0;
    work.st = state_r;
    h       = state_r.held;
    k       = op_kind(in_ch.char_in);
    if (!state_r.err_seen) begin
      if (h != HK_NONE) begin
        work.st.held = HK_NONE;
        if (k != HK_NONE) begin
          // Only a doubled bar or ampersand forms a two-byte operator.
          if (k == h && k != HK_SEMI) begin
            work = f_emit_op(work, (h == HK_BAR) ? OP_OR : OP_AND);
          end else begin
            work = f_error(work, ERR_BAD_PAIR);
          end
        end else begin
          work = f_resolve(work, h);
          if (!work.st.err_seen) begin
            work = f_process(work, in_ch.char_in);
          end
        end
      end else begin
        work = f_process(work, in_ch.char_in);
      end
      if (in_ch.end_of_line && !work.st.err_seen) begin
        if (work.st.held != HK_NONE) begin
          h = work.st.held;
          work.st.held = HK_NONE;
          work = f_resolve(work, h);
        end
        if (!work.st.err_seen) begin
          work = f_close(work);
        end
      end
    end
    if (in_ch.end_of_line) begin
      work = f_put(work, mk_res(EV_LINE_END, 8'd0, 1'b0, OP_PIPE, ERR_BAD_PAIR));
      work.st = '0;
    end
  end

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign push        = accept && (work.n != 3'd0);

  always_comb begin
    push_data.res      = work.res;
    push_data.last_idx = 2'(work.n - 3'd1);
  end

  always_comb begin
    state_nxt = state_r;
    if (accept) begin
      state_nxt = work.st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/slt_queue.sv -----
`default_nettype none
module slt_queue #(
  parameter int DEPTH = slt_pkg::SLT_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  slt_pkg::slt_bundle_t push_data,
  input  logic                 pop,
  output logic                 full,
  output logic                 empty,
  output slt_pkg::slt_bundle_t head
);
  import slt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  slt_bundle_t   mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/slt_back.sv -----
`default_nettype none
module slt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  slt_pkg::slt_bundle_t head,
  input  logic                 empty,
  output logic                 pop,
  slt_out_if.source            out_ch
);
  import slt_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  slt_res_t   out_res_r;
  logic       out_last_r;
  logic [1:0] idx_r, idx_nxt;
  logic       load;
  logic       at_last;

  assign load    = !empty && (!out_valid_r || out_ch.ready);
  assign at_last = (idx_r == head.last_idx);
  assign pop     = load && at_last;

  always_comb begin
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = at_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r  <= head.res[idx_r];
      out_last_r <= at_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_res   = out_res_r.event_res;
  assign out_ch.char_out    = out_res_r.char_out;
  assign out_ch.word_label  = out_res_r.word_label;
  assign out_ch.op_code     = out_res_r.op_code;
  assign out_ch.error_code  = out_res_r.error_code;
  assign out_ch.last_of_run = out_last_r;

endmodule
`default_nettype wire

// ----- rtl/shell_line_tokenizer.sv -----
`default_nettype none
// Channel   Dir  Payload                                              Handshake
// in_ch     in   char_in[8], end_of_line                             valid/ready
// out_ch    out  event_res[3], char_out[8], word_label, op_code[3],  valid/ready
//                error_code, last_of_run
//
// One byte is accepted per cycle while the bundle queue has room; its results
// leave one per cycle while the receiver is ready.
// The first result beat of a byte passes the queue and then the output register;
// with the receiver ready it is taken at the following edge.
// rst_n is synchronous, active low; it clears the lexer state, the queue and
// the output register. Either side may stall: the queue holds up to QUEUE_DEPTH
// result bundles, and a held output beat keeps its payload until taken.
module shell_line_tokenizer #(
  parameter int QUEUE_DEPTH = slt_pkg::SLT_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  slt_in_if.sink     in_ch,
  slt_out_if.source  out_ch
);
  import slt_pkg::*;

  // The front end lexes each byte against the quote, lookahead and word state
  // and packs every result that byte causes into one bundle.
  logic        push;
  slt_bundle_t push_data;
  logic        q_full;
  logic        q_empty;
  logic        pop;
  slt_bundle_t head;

  slt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Bundles wait here, so a byte that fans out into several results does not
  // stall input until the queue actually fills.
  slt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  // The back end walks each bundle and, while the receiver is ready, presents one
  // result beat per cycle from a registered output, marking each byte's final beat.
  slt_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import slt_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  slt_in_if  in_ch();
  slt_out_if out_ch();

  shell_line_tokenizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // One expected result beat, along with the flag that marks it as the last
  // beat caused by its input byte.
  typedef struct {
    slt_res_t   res;
    logic       last;
  } tok_beat_t;

  // One input beat: a byte, and the flag that marks the end of its line.
  typedef struct {
    logic [7:0] ch;
    logic       eol;
  } line_byte_t;

  line_byte_t  byte_stream[$];     // bytes still waiting to be driven
  logic [7:0]  line_buf[$];        // line under construction
  tok_beat_t   step_beats[$];      // results of the byte being lexed
  tok_beat_t   expected_beats[$];  // results predicted but not yet seen

  int unsigned bytes_queued;
  int unsigned bytes_accepted;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          mismatch_seen;

  // State of the lexer that mirrors the block.
  logic [1:0] quote_state;
  logic [1:0] pending_op;
  logic       in_word;
  logic [1:0] last_token;
  logic       line_broken;

  // ---------------------------------------------------------------------------
  // Lexer used for prediction.
  // ---------------------------------------------------------------------------

  function automatic void note_result(logic [2:0] ev, logic [7:0] ch, logic lab,
                                      logic [2:0] op, logic err);
    tok_beat_t b;
    // A single byte can cause at most SLT_MAX_RES results.
    if (step_beats.size() < SLT_MAX_RES) begin
      b.res.event_res  = ev;
      b.res.char_out   = ch;
      b.res.word_label = lab;
      b.res.op_code    = op;
      b.res.error_code = err;
      b.last           = 1'b0;
      step_beats       = {step_beats, b};
    end
  endfunction

  function automatic logic arg_label();
    return last_token == PK_ARG;
  endfunction

  function automatic logic [1:0] op_byte_kind(logic [7:0] c);
    if (c == CH_BAR) return HK_BAR;
    if (c == CH_AMP) return HK_AMP;
    if (c == CH_SEMI) return HK_SEMI;
    return HK_NONE;
  endfunction

  function automatic void clear_lexer();
    quote_state = QM_NORMAL;
    pending_op  = HK_NONE;
    in_word     = 1'b0;
    last_token  = PK_NONE;
    line_broken = 1'b0;
  endfunction

  // An error drops the held operator and the open word, and the rest of the
  // line is ignored.
  function automatic void fail_line(logic code);
    note_result(EV_ERR, 8'h00, 1'b0, OP_PIPE, code);
    line_broken = 1'b1;
    pending_op  = HK_NONE;
    in_word     = 1'b0;
  endfunction

  // An operator is legal only when the token just before it was a word.
  function automatic void put_operator(logic [2:0] code);
    if (last_token == PK_CMD || last_token == PK_ARG) begin
      note_result(EV_OP, 8'h00, 1'b0, code, ERR_BAD_PAIR);
      last_token = PK_OP;
    end else begin
      fail_line(ERR_BAD_PLACE);
    end
  endfunction

  function automatic void resolve_single(logic [1:0] held);
    case (held)
      HK_BAR:  put_operator(OP_PIPE);
      HK_AMP:  put_operator(OP_DETACH);
      default: put_operator(OP_SEMI);
    endcase
  endfunction

  // The first byte of a word makes it an argument when a word came just
  // before it, and a command otherwise.
  function automatic void word_byte(logic [7:0] c);
    if (!in_word) begin
      in_word    = 1'b1;
      last_token = (last_token == PK_CMD || last_token == PK_ARG) ? PK_ARG : PK_CMD;
    end
    note_result(EV_BYTE, c, arg_label(), OP_PIPE, ERR_BAD_PAIR);
  endfunction

  function automatic void close_word();
    if (in_word) begin
      note_result(EV_WORD_END, 8'h00, arg_label(), OP_PIPE, ERR_BAD_PAIR);
      in_word = 1'b0;
    end
  endfunction

  function automatic void lex_char(logic [7:0] c);
    logic [1:0] kind;
    kind = op_byte_kind(c);
    if (quote_state == QM_SINGLE) begin
      if (c == CH_SQUOTE) quote_state = QM_NORMAL;
      else word_byte(c);
    end else if (quote_state == QM_DOUBLE) begin
      if (c == CH_DQUOTE) quote_state = QM_NORMAL;
      else word_byte(c);
    end else if (c == CH_SQUOTE) begin
      quote_state = QM_SINGLE;
    end else if (c == CH_DQUOTE) begin
      quote_state = QM_DOUBLE;
    end else if (c == CH_SPACE || c == CH_TAB) begin
      close_word();
    end else if (kind != HK_NONE) begin
      close_word();
      pending_op = kind;
    end else begin
      word_byte(c);
    end
  endfunction

  // Advances the lexer by one accepted byte and appends its results to the
  // expected queue.
  function automatic void lex_step(logic [7:0] c, logic eol);
    logic [1:0] held;
    logic [1:0] kind;
    step_beats.delete();
    if (!line_broken) begin
      if (pending_op != HK_NONE) begin
        // The held operator is resolved with this byte as lookahead. Only a
        // repeated bar or ampersand pairs up; any other operator byte is a
        // bad pair.
        held       = pending_op;
        kind       = op_byte_kind(c);
        pending_op = HK_NONE;
        if (kind != HK_NONE) begin
          if (kind == held && kind != HK_SEMI)
            put_operator(held == HK_BAR ? OP_OR : OP_AND);
          else
            fail_line(ERR_BAD_PAIR);
        end else begin
          resolve_single(held);
          if (!line_broken) lex_char(c);
        end
      end else begin
        lex_char(c);
      end
      // At the end of a line, a trailing operator is resolved and an open word
      // is closed. An unclosed quote just ends the word.
      if (eol && !line_broken) begin
        if (pending_op != HK_NONE) begin
          held       = pending_op;
          pending_op = HK_NONE;
          resolve_single(held);
        end
        if (!line_broken) close_word();
      end
    end
    if (eol) begin
      note_result(EV_LINE_END, 8'h00, 1'b0, OP_PIPE, ERR_BAD_PAIR);
      clear_lexer();
    end
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
    expected_beats = {expected_beats, step_beats};
  endfunction

  // ---------------------------------------------------------------------------
  // Building the lines.
  // ---------------------------------------------------------------------------

  task automatic push_byte(logic [7:0] b);
    line_buf = {line_buf, b};
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf = {line_buf, 8'(s[i])};
  endtask

  // The line under construction is moved to the input stream, and its last
  // byte carries the end of line flag.
  task automatic end_line();
    line_byte_t lb;
    foreach (line_buf[i]) begin
      lb.ch       = line_buf[i];
      lb.eol      = (i == line_buf.size() - 1);
      byte_stream = {byte_stream, lb};
    end
    bytes_queued += line_buf.size();
    line_buf.delete();
  endtask

  // A byte that is most often one of those with special meaning.
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 9))
      0: return CH_BAR;
      1: return CH_AMP;
      2: return CH_SEMI;
      3: return CH_SQUOTE;
      4: return CH_DQUOTE;
      5: return CH_SPACE;
      6: return CH_TAB;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_gap();
    if ($urandom_range(0, 1)) push_byte(CH_SPACE);
    else push_byte(CH_TAB);
    if ($urandom_range(0, 3) == 0) push_byte(CH_SPACE);
  endtask

  // Either one of the five legal operators or a broken run of operator bytes,
  // which gives bad pairs and misplaced operators.
  task automatic push_op(bit broken);
    if (broken) begin
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(0, 2))
          0: push_byte(CH_BAR);
          1: push_byte(CH_AMP);
          default: push_byte(CH_SEMI);
        endcase
      end
    end else begin
      case ($urandom_range(0, 4))
        0: push_text("|");
        1: push_text("&");
        2: push_text(";");
        3: push_text("||");
        default: push_text("&&");
      endcase
    end
    if ($urandom_range(0, 1)) push_gap();
  endtask

  // ---------------------------------------------------------------------------
  // Driver. It sends the bytes of byte_stream, idles at random, and has the
  // lexer predict the results of every byte that the block accepts.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    line_byte_t lb;
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.char_in     <= 8'h00;
      in_ch.end_of_line <= 1'b0;
      clear_lexer();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        lex_step(in_ch.char_in, in_ch.end_of_line);
        bytes_accepted++;
      end
      // A new beat may be put up only when the bus is empty or its beat has
      // just been taken.
      if (!in_ch.valid || in_ch.ready) begin
        if (byte_stream.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          lb = byte_stream.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.char_in     <= lb.ch;
          in_ch.end_of_line <= lb.eol;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. It stalls at random and checks every result beat it takes
  // against the oldest expected beat.
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_seen = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    tok_beat_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with event %0d arrived with no result expected",
                 out_ch.event_res);
          mismatch_seen = 1'b1;
        end else begin
          want = expected_beats.pop_front();
          check_field("event_res", 32'(want.res.event_res), 32'(out_ch.event_res));
          check_field("char_out", 32'(want.res.char_out), 32'(out_ch.char_out));
          check_field("word_label", 32'(want.res.word_label), 32'(out_ch.word_label));
          check_field("op_code", 32'(want.res.op_code), 32'(out_ch.op_code));
          check_field("error_code", 32'(want.res.error_code), 32'(out_ch.error_code));
          check_field("last_of_run", 32'(want.last), 32'(out_ch.last_of_run));
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus. There are four phases of idling: none, a sender that is mostly
  // idle, a receiver that mostly stalls, and both of them idling now and then.
  // Each phase adds about 80 random bytes, and the stream is drained before
  // the next phase starts.
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned send_idle_tbl[4];
    int unsigned recv_stall_tbl[4];
    int unsigned target;
    int unsigned style;
    int unsigned n_cmds;
    int unsigned n_words;
    int unsigned n_pieces;
    logic [7:0]  q;
    logic [7:0]  b;

    send_idle_tbl  = '{0, 68, 0, 22};
    recv_stall_tbl = '{0, 0, 68, 22};
    rst_n             = 1'b0;
    bytes_queued      = 0;
    bytes_accepted    = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    mismatch_seen     = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // The directed lines.
    // The first holds the extreme byte values in a word that a quoted
    // operator continues, an empty quoted span standing alone, the and and or
    // pairs, a tab as a blank, and a trailing semicolon resolved at the end
    // of the line.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("';' \"\"&&c||d\te;");
    end_line();
    // A lone operator with no word before it is misplaced.
    push_text("|");
    end_line();
    // An ampersand followed by a bar is a bad pair, and the byte after it is
    // ignored.
    push_text("a&|b");
    end_line();
    // Single pipe and detach operators, and then a quote that is never
    // closed.
    push_text("x|y&\"z");
    end_line();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_idle_tbl[ph];
      recv_stall_pct = recv_stall_tbl[ph];
      target         = bytes_queued + 80;
      while (bytes_queued < target) begin
        style = $urandom_range(0, 99);
        if (style < 12) begin
          // Pure noise.
          repeat ($urandom_range(1, 8)) push_byte(noise_byte());
        end else begin
          // A sequence of commands. In about one line out of seven, the
          // operators are broken, or the line opens with an operator.
          if (style < 27 && $urandom_range(0, 2) == 0) push_op(1'b1);
          n_cmds = $urandom_range(1, 3);
          for (int ci = 0; ci < n_cmds; ci++) begin
            if (ci > 0) push_op(style < 27);
            n_words = $urandom_range(1, 3);
            for (int wi = 0; wi < n_words; wi++) begin
              if (wi > 0) push_gap();
              n_pieces = $urandom_range(1, 3);
              for (int pi = 0; pi < n_pieces; pi++) begin
                if ($urandom_range(0, 3) == 0) begin
                  // A quoted span, which may be empty. Any byte but the
                  // closing quote can stand inside it. Now and then the
                  // closing quote is left out.
                  q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                  push_byte(q);
                  repeat ($urandom_range(0, 3)) begin
                    b = 8'($urandom_range(0, 255));
                    while (b == q) b = 8'($urandom_range(0, 255));
                    push_byte(b);
                  end
                  if ($urandom_range(0, 24) != 0) push_byte(q);
                end else begin
                  // A plain word byte: often a letter, otherwise any byte
                  // with no special meaning.
                  if ($urandom_range(0, 1)) begin
                    b = 8'($urandom_range(8'h61, 8'h7A));
                  end else begin
                    b = 8'($urandom_range(0, 255));
                    while (op_byte_kind(b) != HK_NONE || b == CH_SQUOTE ||
                           b == CH_DQUOTE || b == CH_SPACE || b == CH_TAB)
                      b = 8'($urandom_range(0, 255));
                  end
                  push_byte(b);
                end
              end
            end
          end
          if ($urandom_range(0, 4) == 0) push_op(style < 27);
          if ($urandom_range(0, 5) == 0) push_gap();
        end
        end_line();
      end
      // Drain the stream and every expected beat before the idling changes.
      while (bytes_accepted != bytes_queued || expected_beats.size() != 0)
        @(posedge clk);
    end

    // Give a stray beat time to come out before the verdict.
    repeat (20) @(posedge clk);
    if (!mismatch_seen) begin
      $display("** shell_line_tokenizer: PASSED **");
    end else begin
      $display("** shell_line_tokenizer: FAILED **");
    end
    $finish;
  end

  // Watchdog. A correct run ends within a few tens of microseconds, so this
  // bound leaves a wide margin.
  initial begin
    #2ms;
    $display("** shell_line_tokenizer: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/slt_pkg.sv
rtl/slt_if.sv
rtl/slt_front.sv
rtl/slt_queue.sv
rtl/slt_back.sv
rtl/shell_line_tokenizer.sv
sim/tb_top.sv
